// ===== rtl/mvsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvsm_pkg: shared types and codes of the sample mixer
// Request and result codes, the queued command and the voice record layout.
// ----------------------------------------------------------------------------
package mvsm_pkg;

	// request codes carried in s_tuser
	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_MIX   = 2'd2;
	localparam logic [1:0] REQ_BAD   = 2'd3;

	// result codes carried in m_tuser
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_MIX   = 1'b1;

	localparam int S_DATA_W = 72;
	localparam int M_DATA_W = 32;

	localparam logic signed [15:0] Q15_MAX = 16'sh7fff;
	localparam logic signed [15:0] Q15_MIN = -16'sh8000;

	// one queued request
	typedef struct packed {
		logic [1:0]         req_type;
		logic [15:0]        address;
		logic signed [15:0] sample_value;
		logic [15:0]        sound_frames;
		logic               sound_stereo;
		logic               loop_enable;
		logic [15:0]        voice_gain;
	} cmd_t;

	// one voice table entry
	typedef struct packed {
		logic [15:0] base;
		logic [15:0] length;
		logic [15:0] position;
		logic [15:0] volume;
		logic        stereo;
		logic        loops;
	} voice_rec_t;

endpackage

// ===== rtl/multi_voice_sample_mixer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_voice_sample_mixer_unit: wavetable voice mixer
// Sample memory plus a table of playback voices, mixed into output frames.
// ----------------------------------------------------------------------------
// Requests are queued two deep and then run one at a time. A load writes the
// sample memory straight from the idle state. A start is dispatched from the
// idle state, scans the voice table for the lowest idle voice and sends its
// reply, a failed one if no voice is idle. A mix is dispatched from the idle
// state and walks every voice once: an idle voice is skipped, one that ends
// is retired after its voice table read, and one that plays goes through a
// voice table read, two sample memory reads through its single read port,
// scale and accumulate; after the walk the frame is sent, one sample per output
// channel. The result register lets the next request start while a result
// waits. SAMPLE_WORDS must be a power of two; sample addresses wrap at that
// size. The sample memory is not cleared by reset and must be loaded before it
// is played.
module multi_voice_sample_mixer_unit #(
	parameter int NUM_VOICES   = 64,
	parameter int SAMPLE_WORDS = 65536,
	parameter int MAX_CHANNELS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration: output channel count
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [3:0]                    cfg_data,
	// requests
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [1:0]                    s_tuser, // req_type
	// address, sample_value, sound_frames, sound_stereo, loop_enable, voice_gain
	input  logic [mvsm_pkg::S_DATA_W-1:0] s_tdata,
	// results
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// start_ok, voice_index, channel_index, mixed_sample
	output logic [mvsm_pkg::M_DATA_W-1:0] m_tdata,
	output logic                          m_tuser, // result_kind
	output logic                          m_tlast  // last_channel
);
	import mvsm_pkg::*;

	logic [3:0] chan_cfg_q;
	cmd_t       cmd;
	logic       cmd_valid;
	logic       cmd_ready;

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_cfg_q <= 4'd2;
		end else if (cfg_valid) begin
			chan_cfg_q <= cfg_data;
		end
	end

	mvsm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready)
	);

	mvsm_back #(
		.NUM_VOICES   (NUM_VOICES),
		.SAMPLE_WORDS (SAMPLE_WORDS),
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.chan_cfg     (chan_cfg_q),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.m_tlast      (m_tlast)
	);

	// a frame end mark only on mixed samples
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == KIND_MIX)
		else $error("last mark on a start reply");

	// a failed start names no voice
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_START && !m_tdata[0] |-> m_tdata[6:1] == 6'd0)
		else $error("failed start carries a voice index");

	// the engine never pops an empty queue
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_ready |-> cmd_valid)
		else $error("request queue popped while empty");
endmodule

// ===== rtl/mvsm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvsm_ram: generic single-write, single-read RAM
// One write and one read port, read data registered.
// ----------------------------------------------------------------------------
module mvsm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/mvsm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvsm_front: request intake
// Takes input transactions, drops unknown request codes and queues the rest
// in a two-entry queue towards the engine.
// ----------------------------------------------------------------------------
module mvsm_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [1:0]                        s_tuser, // req_type
	input  logic [mvsm_pkg::S_DATA_W-1:0]     s_tdata,
	output mvsm_pkg::cmd_t                    cmd,
	output logic                              cmd_valid,
	input  logic                              cmd_ready
);
	import mvsm_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;
	cmd_t       incoming;

	// unpack the bus
	always_comb begin
		incoming.req_type     = s_tuser;
		incoming.address      = s_tdata[15:0];
		incoming.sample_value = s_tdata[31:16];
		incoming.sound_frames = s_tdata[47:32];
		incoming.sound_stereo = s_tdata[48];
		incoming.loop_enable  = s_tdata[49];
		incoming.voice_gain   = s_tdata[65:50];
	end

	assign s_tready  = (cnt_q != 2'd2);
	assign push      = s_tvalid && s_tready && (s_tuser != REQ_BAD) && (s_tdata[71:66] == 6'd0
			|| s_tdata[71:66] != 6'd0);
	assign cmd_valid = (cnt_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = slot_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= incoming;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)      cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end
endmodule

// ===== rtl/mvsm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvsm_back: request engine
// Runs loads, voice starts and frame mixes one at a time over the sample
// memory and the voice table, and drives the registered result port.
// ----------------------------------------------------------------------------
module mvsm_back #(
	parameter int NUM_VOICES   = 64,
	parameter int SAMPLE_WORDS = 65536,
	parameter int MAX_CHANNELS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mvsm_pkg::cmd_t                cmd,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  logic [3:0]                    chan_cfg,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [mvsm_pkg::M_DATA_W-1:0] m_tdata,
	output logic                          m_tuser,
	output logic                          m_tlast
);
	import mvsm_pkg::*;

	localparam int VW     = NUM_VOICES > 1 ? $clog2(NUM_VOICES) : 1;
	localparam int VCW    = $clog2(NUM_VOICES + 1);
	localparam int SAW    = SAMPLE_WORDS > 1 ? $clog2(SAMPLE_WORDS) : 1;
	localparam int AWIDE  = SAW > 18 ? SAW : 18;
	localparam int CH_LIM = MAX_CHANNELS < 8 ? MAX_CHANNELS : 8;
	localparam int ACC_W  = 19 + VW;
	localparam int RW     = $bits(voice_rec_t);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SCAN  = 4'd1;
	localparam logic [3:0] ST_REPLY = 4'd2;
	localparam logic [3:0] ST_VRD   = 4'd3;
	localparam logic [3:0] ST_VCHK  = 4'd4;
	localparam logic [3:0] ST_S0    = 4'd5;
	localparam logic [3:0] ST_S1    = 4'd6;
	localparam logic [3:0] ST_ACC   = 4'd7;
	localparam logic [3:0] ST_EMIT  = 4'd8;

	logic [3:0]                state_q;
	logic [NUM_VOICES-1:0]     active_q;
	logic [VCW-1:0]            vcnt_q;
	logic [2:0]                ch_q;
	logic signed [ACC_W-1:0]   acc_q [8];
	logic [SAW-1:0]            a0_q;
	logic                      stereo_q;
	logic [15:0]               vol_q;
	logic signed [32:0]        prod0_q;
	logic signed [32:0]        prod1_q;
	logic                      ok_q;
	logic [VW-1:0]             found_q;

	logic                      m_tvalid_q;
	logic [M_DATA_W-1:0]       m_tdata_q;
	logic                      m_tuser_q;
	logic                      m_tlast_q;

	logic [VW-1:0]             vidx;
	logic [3:0]                nch;
	logic                      out_free;
	logic                      emit_now;
	voice_rec_t                rec_rd;
	voice_rec_t                rec_new;
	voice_rec_t                rec_upd;
	logic                      at_end;
	logic                      retire;
	logic [15:0]               pos_eff;
	logic [AWIDE-1:0]          a0_wide;
	logic [AWIDE-1:0]          ld_wide;
	logic [SAW-1:0]            a0;
	logic                      vram_we;
	logic [RW-1:0]             vram_wdata;
	logic [RW-1:0]             vram_rdata;
	logic                      sram_we;
	logic [SAW-1:0]            sram_raddr;
	logic [15:0]               sram_rdata;
	logic signed [17:0]        contrib0;
	logic signed [17:0]        contrib1;
	logic signed [15:0]        sat_val;

	function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
		logic signed [15:0] r;
		if (v > ACC_W'(Q15_MAX))      r = Q15_MAX;
		else if (v < ACC_W'(Q15_MIN)) r = Q15_MIN;
		else                          r = v[15:0];
		return r;
	endfunction

	assign vidx     = vcnt_q[VW-1:0];
	assign out_free = !m_tvalid_q || m_tready;
	assign emit_now = out_free && (state_q == ST_REPLY || state_q == ST_EMIT);
	assign rec_rd   = voice_rec_t'(vram_rdata);

	// effective channel count
	always_comb begin
		if (chan_cfg == 4'd0)              nch = 4'd1;
		else if (chan_cfg > 4'(CH_LIM))    nch = 4'(CH_LIM);
		else                               nch = chan_cfg;
	end

	// new voice record for a start
	always_comb begin
		rec_new.base     = cmd.address;
		rec_new.length   = cmd.sound_frames;
		rec_new.position = 16'd0;
		rec_new.volume   = cmd.voice_gain;
		rec_new.stereo   = cmd.sound_stereo;
		rec_new.loops    = cmd.loop_enable;
	end

	// end-of-sound check and first sample address
	always_comb begin
		at_end  = rec_rd.position >= rec_rd.length;
		retire  = at_end && !(rec_rd.loops && rec_rd.length != 16'd0);
		pos_eff = at_end ? 16'd0 : rec_rd.position;
		rec_upd = rec_rd;
		rec_upd.position = pos_eff + 16'd1;
		a0_wide = AWIDE'(rec_rd.base) + (rec_rd.stereo ? AWIDE'({pos_eff, 1'b0})
				: AWIDE'(pos_eff));
		a0      = a0_wide[SAW-1:0];
		ld_wide = AWIDE'(cmd.address);
	end

	// memory port control
	always_comb begin
		vram_we    = 1'b0;
		vram_wdata = RW'(rec_upd);
		if (state_q == ST_SCAN && vcnt_q != VCW'(NUM_VOICES) && !active_q[vidx]) begin
			vram_we    = 1'b1;
			vram_wdata = RW'(rec_new);
		end else if (state_q == ST_VCHK && !retire) begin
			vram_we = 1'b1;
		end
		sram_we    = (state_q == ST_IDLE) && cmd_valid && (cmd.req_type == REQ_LOAD);
		sram_raddr = (state_q == ST_S0) ? a0_q + SAW'(1) : a0;
	end

	assign cmd_ready = sram_we
			|| (state_q == ST_REPLY && out_free)
			|| (state_q == ST_EMIT && out_free && ({1'b0, ch_q} + 4'd1 == nch));

	assign contrib0 = prod0_q[32:15];
	assign contrib1 = prod1_q[32:15];
	assign sat_val  = sat16(acc_q[ch_q]);

	mvsm_ram #(.WIDTH(RW), .DEPTH(NUM_VOICES)) u_voice_ram (
		.clk   (clk),
		.we    (vram_we),
		.waddr (vidx),
		.wdata (vram_wdata),
		.raddr (vidx),
		.rdata (vram_rdata)
	);

	mvsm_ram #(.WIDTH(16), .DEPTH(SAMPLE_WORDS)) u_sample_ram (
		.clk   (clk),
		.we    (sram_we),
		.waddr (ld_wide[SAW-1:0]),
		.wdata (cmd.sample_value),
		.raddr (sram_raddr),
		.rdata (sram_rdata)
	);

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				for (int c = 0; c < 8; c++) acc_q[c] <= '0;
			end
			ST_VCHK: begin
				a0_q     <= a0;
				stereo_q <= rec_rd.stereo;
				vol_q    <= rec_rd.volume;
			end
			ST_S0: begin
				prod0_q <= $signed(sram_rdata) * $signed({1'b0, vol_q});
			end
			ST_S1: begin
				prod1_q <= $signed(sram_rdata) * $signed({1'b0, vol_q});
			end
			ST_ACC: begin
				for (int c = 0; c < 8; c++) begin
					acc_q[c] <= acc_q[c] + ACC_W'((stereo_q && c[0]) ? contrib1 : contrib0);
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			active_q   <= '0;
			vcnt_q     <= '0;
			ch_q       <= '0;
			ok_q       <= 1'b0;
			found_q    <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= 1'b0;
			m_tlast_q  <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && !emit_now) m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					vcnt_q <= '0;
					ch_q   <= '0;
					if (cmd_valid && cmd.req_type == REQ_START)    state_q <= ST_SCAN;
					else if (cmd_valid && cmd.req_type == REQ_MIX) state_q <= ST_VRD;
				end
				ST_SCAN: begin
					if (vcnt_q == VCW'(NUM_VOICES)) begin
						ok_q    <= 1'b0;
						found_q <= '0;
						state_q <= ST_REPLY;
					end else if (!active_q[vidx]) begin
						active_q[vidx] <= 1'b1;
						ok_q    <= 1'b1;
						found_q <= vidx;
						state_q <= ST_REPLY;
					end else begin
						vcnt_q <= vcnt_q + VCW'(1);
					end
				end
				ST_REPLY: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= KIND_START;
						m_tlast_q  <= 1'b0;
						m_tdata_q  <= {6'd0, 16'd0, 3'd0, (ok_q ? 6'(found_q) : 6'd0), ok_q};
						state_q    <= ST_IDLE;
					end
				end
				ST_VRD: begin
					if (vcnt_q == VCW'(NUM_VOICES)) state_q <= ST_EMIT;
					else if (!active_q[vidx])       vcnt_q  <= vcnt_q + VCW'(1);
					else                            state_q <= ST_VCHK;
				end
				ST_VCHK: begin
					if (retire) begin
						active_q[vidx] <= 1'b0;
						vcnt_q  <= vcnt_q + VCW'(1);
						state_q <= ST_VRD;
					end else begin
						state_q <= ST_S0;
					end
				end
				ST_S0: state_q <= ST_S1;
				ST_S1: state_q <= ST_ACC;
				ST_ACC: begin
					vcnt_q  <= vcnt_q + VCW'(1);
					state_q <= ST_VRD;
				end
				ST_EMIT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= KIND_MIX;
						m_tlast_q  <= ({1'b0, ch_q} + 4'd1 == nch);
						m_tdata_q  <= {6'd0, sat_val, ch_q, 6'd0, 1'b0};
						ch_q       <= ch_q + 3'd1;
						if ({1'b0, ch_q} + 4'd1 == nch) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;
endmodule
